/* rtl/ted_pkg.sv */
// Shared constants, types and helpers for the threshold edge detector.
`timescale 1ns / 1ps
`default_nettype none

package ted_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int PIXEL_BITS    = 8;
    localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_W = WIDTH_BITS'(MAX_WIDTH);

    typedef logic [PIXEL_BITS-1:0] t_pixel;

    localparam t_pixel EDGE_ON = '1;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    // One pending result on its way to the output register
    typedef struct packed {
        logic   is_pixel;
        logic   has_right;
        t_pixel up;
        t_pixel px;
        logic   frame_end;
    } t_item;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        t_pixel               wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } t_ram_req;

    function automatic t_pixel abs_diff(input t_pixel a, input t_pixel b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

/* rtl/ted_line_ram.sv */
// Line buffer: one write and one registered read per cycle, read-first.
`timescale 1ns / 1ps
`default_nettype none

module ted_line_ram
    import ted_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_ram_req i_req,
    output t_pixel        o_rdata
);

    t_pixel r_mem [MAX_WIDTH];
    t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/ted_ctrl.sv */
// Raster position counters, flush sequencing and line buffer addressing.
`timescale 1ns / 1ps
`default_nettype none

module ted_ctrl
    import ted_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic                   i_opcode,
    input  wire t_pixel                 i_pixel_value,
    input  wire logic [WIDTH_BITS-1:0]  i_width,
    input  wire logic [HEIGHT_BITS-1:0] i_height,
    input  wire t_pixel                 i_rdata,
    output t_ram_req                    o_ram,
    output logic                        o_issue,
    output t_item                       o_item
);

    logic [HEIGHT_BITS-1:0] r_row, n_row;
    logic [ADDR_BITS-1:0]   r_col, n_col;
    logic [ADDR_BITS-1:0]   r_flush, n_flush;
    t_pixel                 r_col0, n_col0;

    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [HEIGHT_BITS-1:0] row_pre;
    logic [ADDR_BITS-1:0]   col_pre;
    logic [WIDTH_BITS-1:0]  col_inc;
    logic [WIDTH_BITS-1:0]  flush_inc;
    logic                   has_right;

    always_comb begin
        if (i_width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (i_width > MAX_WIDTH_W) begin
            w_eff = MAX_WIDTH_W;
        end else begin
            w_eff = i_width;
        end
        h_eff = (i_height == '0) ? HEIGHT_BITS'(1) : i_height;
    end

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_flush = r_flush;
        n_col0  = r_col0;
        o_issue = 1'b0;
        o_item  = '0;
        o_ram   = '0;

        // Close a row left open by a shrunk width
        row_pre = r_row;
        col_pre = r_col;
        if (r_row < h_eff && {1'b0, r_col} >= w_eff) begin
            col_pre = '0;
            row_pre = r_row + HEIGHT_BITS'(1);
        end

        col_inc   = {1'b0, col_pre} + WIDTH_BITS'(1);
        flush_inc = {1'b0, r_flush} + WIDTH_BITS'(1);
        has_right = col_inc < w_eff;

        o_item.up        = (col_pre == '0) ? r_col0 : i_rdata;
        o_item.px        = i_pixel_value;
        o_item.has_right = has_right;
        o_item.is_pixel  = (t_op'(i_opcode) == OP_PIXEL);

        if (i_accept) begin
            n_row = row_pre;
            n_col = col_pre;
            if (t_op'(i_opcode) == OP_PIXEL) begin
                if (row_pre < h_eff) begin
                    o_issue     = (row_pre != '0);
                    o_ram.we    = 1'b1;
                    o_ram.waddr = col_pre;
                    o_ram.wdata = i_pixel_value;
                    // Fetch the right neighbor; it is also the next pixel's up value
                    o_ram.re    = has_right;
                    o_ram.raddr = col_inc[ADDR_BITS-1:0];
                    if (col_pre == '0) begin
                        n_col0 = i_pixel_value;
                    end
                    if (col_inc >= w_eff) begin
                        n_col = '0;
                        n_row = row_pre + HEIGHT_BITS'(1);
                    end else begin
                        n_col = col_inc[ADDR_BITS-1:0];
                    end
                end
            end else if (row_pre >= h_eff) begin
                o_issue = 1'b1;
                if (flush_inc >= w_eff) begin
                    o_item.frame_end = 1'b1;
                    n_row   = '0;
                    n_col   = '0;
                    n_flush = '0;
                end else begin
                    n_flush = flush_inc[ADDR_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_flush <= '0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col0 <= n_col0;
    end

endmodule

`default_nettype wire

/* rtl/ted_out_stage.sv */
// Compare stage and output register with handshake on the result side.
`timescale 1ns / 1ps
`default_nettype none

module ted_out_stage
    import ted_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_item  i_item,
    input  wire t_pixel i_right,
    input  wire t_pixel i_threshold,
    output logic        o_can_take,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_pixel      o_edge_value,
    output logic        o_frame_end
);

    logic   r_s1_valid;
    t_item  r_s1;
    logic   r_o_valid;
    t_pixel r_edge;
    logic   r_frame_end;
    logic   s1_adv;
    logic   is_edge;

    assign s1_adv     = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_can_take = !r_s1_valid || s1_adv;

    // Right neighbor sits in the buffer read register while this stage holds
    assign is_edge = r_s1.is_pixel && r_s1.has_right &&
                     ((abs_diff(r_s1.up, i_right) > i_threshold) ||
                      (abs_diff(r_s1.up, r_s1.px) > i_threshold));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_item;
        end
        if (s1_adv) begin
            r_edge      <= is_edge ? EDGE_ON : '0;
            r_frame_end <= r_s1.frame_end;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_edge_value = r_edge;
    assign o_frame_end  = r_frame_end;

endmodule

`default_nettype wire

/* rtl/threshold_edge_detector.sv */
// Top level of the streaming threshold edge detector.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock (a pixel in raster order, or a flush tick) and
// returns the edge map one row behind: 255 where the pixel differs from its
// right or lower neighbor by more than the threshold, else 0; the last
// column and last row are 0. A result passes from the compare stage
// register into the output register, and a new word is taken every cycle
// while the output drains: the line buffer is read once (right neighbor)
// and written once per pixel, at different entries. With the output held,
// two results back up and the input stalls until the output takes a word.
// After the last pixel, send one flush tick per column to drain the zero
// row; the last result carries frame_end. Program width and height only
// while idle; the buffer holds no defined data until its first row is in.
module threshold_edge_detector
    import ted_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_opcode,
    input  wire logic [PIXEL_BITS-1:0]    i_pixel_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [PIXEL_BITS-1:0]         o_edge_value,
    output logic                          o_frame_end
);

    t_pixel                 r_threshold;
    logic [WIDTH_BITS-1:0]  r_image_width;
    logic [HEIGHT_BITS-1:0] r_image_height;

    logic     accept;
    logic     can_take;
    logic     issue;
    t_item    item;
    t_ram_req ram_req;
    t_pixel   rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= '0;
            r_image_width  <= MAX_WIDTH_W;
            r_image_height <= HEIGHT_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:    r_threshold    <= i_cfg_wdata[PIXEL_BITS-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = can_take;
    assign accept     = i_in_valid && can_take;

    ted_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_pixel_value (i_pixel_value),
        .i_width       (r_image_width),
        .i_height      (r_image_height),
        .i_rdata       (rdata),
        .o_ram         (ram_req),
        .o_issue       (issue),
        .o_item        (item)
    );

    ted_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    ted_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (issue),
        .i_item       (item),
        .i_right      (rdata),
        .i_threshold  (r_threshold),
        .o_can_take   (can_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_edge_value (o_edge_value),
        .o_frame_end  (o_frame_end)
    );

endmodule

`default_nettype wire

/* sim/tb_threshold_edge_detector.sv */
// Self-checking testbench for the streaming threshold edge detector.
`timescale 1ns / 1ps

module tb_threshold_edge_detector;
    import ted_pkg::*;

    localparam int RANDOM_WORDS = 800;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int SHOW_LIMIT   = 40;
    localparam int SHORT_ROW    = 64;

    typedef struct packed {
        t_pixel edge_px;
        logic   frame_end;
    } t_edge_word;

    // Tracks the line buffer and counters, and lines up the edge map it implies
    class edge_map_tracker;
        t_pixel                 threshold;
        logic [WIDTH_BITS-1:0]  width_reg;
        logic [HEIGHT_BITS-1:0] height_reg;
        t_pixel                 line_buf [MAX_WIDTH];
        int unsigned            row_cnt;
        int unsigned            col_cnt;
        int unsigned            flush_cnt;
        t_edge_word             edges_due [$];
        int unsigned            errors;
        int unsigned            words;
        int unsigned            checked;
        int unsigned            edges;
        int unsigned            frames;

        function new();
            threshold  = '0;
            width_reg  = WIDTH_BITS'(MAX_WIDTH);
            height_reg = HEIGHT_BITS'(1);
            foreach (line_buf[k]) line_buf[k] = '0;
            row_cnt    = 0;
            col_cnt    = 0;
            flush_cnt  = 0;
            errors     = 0;
            words      = 0;
            checked    = 0;
            edges      = 0;
            frames     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_THRESHOLD:    threshold = val[PIXEL_BITS-1:0];
                CFG_IMAGE_WIDTH:  width_reg = val[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_reg = val[HEIGHT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned pixel_gap(t_pixel a, t_pixel b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        // True when the next word lands after the last row is in
        function bit flushing();
            int unsigned rows;
            rows = row_cnt;
            if (rows < eff_height() && col_cnt >= eff_width()) rows++;
            return rows >= eff_height();
        endfunction

        function void note_word(t_op op, t_pixel px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            t_edge_word  res;
            w = eff_width();
            h = eff_height();
            words++;
            // a shrunk width can leave the column past the row end
            if (row_cnt < h && col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (op == OP_PIXEL) begin
                if (row_cnt >= h) return;
                c = col_cnt;
                if (row_cnt >= 1) begin
                    res.edge_px   = '0;
                    res.frame_end = 1'b0;
                    if (c + 1 < w && c + 1 < MAX_WIDTH) begin
                        if (pixel_gap(line_buf[c], line_buf[c + 1]) > threshold ||
                            pixel_gap(line_buf[c], px) > threshold)
                            res.edge_px = EDGE_ON;
                    end
                    edges_due.push_back(res);
                end
                if (c < MAX_WIDTH) line_buf[c] = px;
                col_cnt = c + 1;
                if (col_cnt >= w) begin
                    col_cnt = 0;
                    row_cnt++;
                end
                return;
            end
            if (row_cnt < h) return;
            flush_cnt++;
            res.edge_px   = '0;
            res.frame_end = (flush_cnt >= w);
            edges_due.push_back(res);
            if (res.frame_end) begin
                row_cnt   = 0;
                col_cnt   = 0;
                flush_cnt = 0;
                frames++;
            end
        endfunction

        function void check_edge(t_pixel got_px, logic got_end);
            t_edge_word want;
            if (edges_due.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: unexpected word, edge_value %0d frame_end %0b",
                             $time, got_px, got_end);
                return;
            end
            want = edges_due.pop_front();
            checked++;
            if (got_px == EDGE_ON) edges++;
            if (got_px !== want.edge_px) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: edge_value expected %0d, actual %0d",
                             $time, want.edge_px, got_px);
            end
            if (got_end !== want.frame_end) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: frame_end expected %0b, actual %0b",
                             $time, want.frame_end, got_end);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     opcode = 1'b0;
    logic [PIXEL_BITS-1:0]    pixel = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [PIXEL_BITS-1:0]    edge_value;
    logic                     frame_end;

    edge_map_tracker sb;
    event            hold_ev;
    logic            hold_on = 1'b0;
    int unsigned     in_idle_pct = 16;
    int unsigned     out_idle_pct = 16;
    int unsigned     quiet_cycles = 0;
    int unsigned     stream_words = 0;
    t_pixel          last_px = '0;

    threshold_edge_detector uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_pixel_value (pixel),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_edge_value  (edge_value),
        .o_frame_end   (frame_end)
    );

    always #6 clk = ~clk;

    // Mix flat stretches, small ramps and hard jumps
    function automatic t_pixel next_pixel();
        t_pixel px;
        case ($urandom_range(7))
            0:       px = '0;
            1:       px = '1;
            2, 3, 4: px = t_pixel'($urandom);
            default: px = last_px + t_pixel'($urandom_range(12)) - t_pixel'(6);
        endcase
        last_px = px;
        return px;
    endfunction

    task automatic send_word(input t_op op, input t_pixel px);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        pixel    <= px;
        do @(posedge clk); while (!in_ready);
        sb.note_word(op, px);
    endtask

    // Drop valid, wait out every pending result and the pipeline behind it
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.edges_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input int unsigned val);
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_DATA_BITS'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, CFG_DATA_BITS'(val));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) sb.check_edge(edge_value, frame_end);
            out_ready <= !hold_on && ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Hold off the output long enough to back the block up into its input
    initial begin
        forever begin
            @(hold_ev);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("threshold_edge_detector: mismatch");
            $finish;
        end
    end

    initial begin
        int          i;
        int unsigned phase;
        int unsigned done_frames;
        int unsigned sent;
        int unsigned tweak_at;
        bit          calm;

        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Full-width first row: reset width for a few pixels, then a saturated width
        set_reg(CFG_IMAGE_HEIGHT, 2);
        for (i = 0; i < 16; i++) send_word(OP_PIXEL, next_pixel());
        set_reg(CFG_IMAGE_WIDTH, 2047);
        for (i = 16; i < MAX_WIDTH; i++) send_word(OP_PIXEL, next_pixel());
        -> hold_ev;
        for (i = 0; i < SHORT_ROW; i++) send_word(OP_PIXEL, next_pixel());
        // cut the second row short, then shrink below the flush count
        set_reg(CFG_IMAGE_WIDTH, SHORT_ROW);
        repeat (4) send_word(OP_FLUSH, t_pixel'($urandom));
        set_reg(CFG_IMAGE_WIDTH, 3);
        send_word(OP_FLUSH, t_pixel'($urandom));

        // Hard contrast at threshold 0, stray flush and stray pixel
        set_reg(CFG_THRESHOLD, 0);
        set_reg(CFG_IMAGE_WIDTH, 3);
        set_reg(CFG_IMAGE_HEIGHT, 2);
        send_word(OP_FLUSH, '1);
        send_word(OP_PIXEL, '0);
        send_word(OP_PIXEL, '1);
        send_word(OP_PIXEL, '0);
        send_word(OP_PIXEL, '1);
        send_word(OP_PIXEL, '0);
        send_word(OP_PIXEL, '1);
        send_word(OP_PIXEL, 8'd128);
        repeat (3) send_word(OP_FLUSH, '0);

        // Zero width and height fall back to one
        set_reg(CFG_THRESHOLD, 255);
        set_reg(CFG_IMAGE_WIDTH, 0);
        set_reg(CFG_IMAGE_HEIGHT, 0);
        send_word(OP_PIXEL, '1);
        send_word(OP_FLUSH, '0);

        // Tallest height, then shrink width and height mid-frame
        set_reg(CFG_THRESHOLD, 254);
        set_reg(CFG_IMAGE_WIDTH, 4);
        set_reg(CFG_IMAGE_HEIGHT, 65535);
        send_word(OP_PIXEL, '0);
        send_word(OP_PIXEL, '1);
        send_word(OP_PIXEL, 8'd1);
        set_reg(CFG_IMAGE_WIDTH, 2);
        send_word(OP_PIXEL, '1);
        send_word(OP_PIXEL, '0);
        set_reg(CFG_IMAGE_HEIGHT, 2);
        repeat (2) send_word(OP_FLUSH, '1);

        phase = 0;
        while (stream_words < RANDOM_WORDS) begin
            calm = (phase >= 6 && phase < 14);
            in_idle_pct  = calm ? 0 : 16;
            out_idle_pct = calm ? 0 : 16;
            if ($urandom_range(9) < 6) begin
                case ($urandom_range(9))
                    0:       set_reg(CFG_THRESHOLD, 0);
                    1:       set_reg(CFG_THRESHOLD, 255);
                    2, 3, 4: set_reg(CFG_THRESHOLD, $urandom_range(15));
                    default: set_reg(CFG_THRESHOLD, $urandom_range(255));
                endcase
            end
            if ($urandom_range(9) < 6)
                set_reg(CFG_IMAGE_WIDTH, ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 16));
            if ($urandom_range(9) < 6)
                set_reg(CFG_IMAGE_HEIGHT, ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6));
            repeat ($urandom_range(1, 3)) begin
                done_frames = sb.frames;
                tweak_at = ($urandom_range(7) == 0) ? $urandom_range(1, 20) : 0;
                sent = 0;
                while (sb.frames == done_frames) begin
                    // width only ever shrinks mid-frame, so no unwritten entry is read
                    if (tweak_at != 0 && sent == tweak_at) begin
                        tweak_at = 0;
                        case ($urandom_range(2))
                            0:       set_reg(CFG_THRESHOLD, $urandom_range(255));
                            1:       set_reg(CFG_IMAGE_WIDTH, $urandom_range(sb.eff_width()));
                            default: set_reg(CFG_IMAGE_HEIGHT, $urandom_range(sb.eff_height()));
                        endcase
                    end
                    if (sb.flushing()) begin
                        if ($urandom_range(24) == 0) begin
                            send_word(OP_PIXEL, next_pixel());
                        end else begin
                            send_word(OP_FLUSH, t_pixel'($urandom));
                            sent++;
                        end
                    end else begin
                        if ($urandom_range(29) == 0) begin
                            send_word(OP_FLUSH, t_pixel'($urandom));
                        end else begin
                            send_word(OP_PIXEL, next_pixel());
                            sent++;
                        end
                    end
                end
                stream_words += sent;
            end
            phase++;
        end

        settle();
        if (sb.edges_due.size() != 0)
            $display("%0t: %0d edge-map pixels never arrived", $time, sb.edges_due.size());
        $display("Covered %0d words over %0d frames in %0d config phases,",
                 sb.words, sb.frames, phase);
        $display("with %0d edge-map pixels compared, %0d of them edges.",
                 sb.checked, sb.edges);
        if (sb.errors == 0 && sb.edges_due.size() == 0) begin
            $display("threshold_edge_detector: match");
        end else begin
            $display("threshold_edge_detector: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ted_pkg.sv
rtl/ted_line_ram.sv
rtl/ted_ctrl.sv
rtl/ted_out_stage.sv
rtl/threshold_edge_detector.sv
sim/tb_threshold_edge_detector.sv
